// ----- rtl/priority_resource_worker_dispatcher_top_assert.svh -----
// assertion macros for the worker dispatcher
// included by the top level; no other dependencies
`ifndef PRIORITY_RESOURCE_WORKER_DISPATCHER_TOP_ASSERT_SVH
`define PRIORITY_RESOURCE_WORKER_DISPATCHER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PRWD_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("dispatcher check failed");
`define PRWD_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("dispatcher check failed");
`else
`define PRWD_ASSERT_IMP(label, clk, rst_n, a, b)
`define PRWD_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- rtl/prwd_pkg.sv -----
// shared types and codes of the worker dispatcher
// used by the controller, the datapath and the top level
package prwd_pkg;

	// request types
	localparam logic [1:0] REQ_LOAD    = 2'd0;
	localparam logic [1:0] REQ_SUBMIT  = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;

	// result status codes
	localparam logic [2:0] ST_REJECTED = 3'd0;
	localparam logic [2:0] ST_GRANTED  = 3'd1;
	localparam logic [2:0] ST_RETRY    = 3'd2;
	localparam logic [2:0] ST_LOADED   = 3'd3;
	localparam logic [2:0] ST_RELEASED = 3'd4;
	localparam logic [2:0] ST_INVALID  = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_WORKERS   = 2'd0;
	localparam logic [1:0] CFG_SERVICES  = 2'd1;
	localparam logic [1:0] CFG_THRESHOLD = 2'd2;

	// configuration reset values
	localparam logic [3:0] CFG_WORKERS_RST   = 4'd8;
	localparam logic [4:0] CFG_SERVICES_RST  = 5'd16;
	localparam logic [7:0] CFG_THRESHOLD_RST = 8'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  service_index;
		logic [2:0]  worker_slot;
		logic [15:0] priority_value;
		logic [15:0] resource_amount;
		logic        is_retry;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  granted_slot;
		logic [7:0]  waiting_count;
		logic        high_traffic;
		logic [15:0] rejected_count;
	} rsp_item_t;

	// decoded item kind
	typedef enum logic [1:0] {
		KIND_INVALID,
		KIND_LOAD,
		KIND_SUBMIT,
		KIND_RELEASE
	} kind_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear_step;
		logic capture;
		logic scan_init;
		logic load_write;
		logic scan_issue;
		logic busy_read;
		logic commit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		kind_t kind;
		logic  no_workers;
		logic  scan_last;
		logic  clear_last;
	} dp_status_t;

endpackage

// ----- rtl/prwd_ctrl.sv -----
// sequencing state machine of the worker dispatcher
// depends on prwd_pkg; drives the datapath through ctrl_cmd_t
module prwd_ctrl import prwd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	input  dp_status_t stat,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   rsp_valid_q, rsp_valid_d;

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		rsp_valid_d = rsp_valid_q && rsp_stall;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.scan_init = 1'b1;
				case (stat.kind)
					KIND_LOAD: begin
						cmd.load_write = 1'b1;
						state_d        = S_FINISH;
					end
					KIND_RELEASE: begin
						cmd.busy_read = 1'b1;
						state_d       = S_FINISH;
					end
					KIND_SUBMIT: begin
						state_d = stat.no_workers ? S_FINISH : S_SCAN;
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (stat.scan_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				// last read is folded in at this edge
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.commit  = 1'b1;
					rsp_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

// ----- rtl/prwd_datapath.sv -----
// datapath of the worker dispatcher: config, worker tables, scan, counters
// depends on prwd_pkg; controlled by prwd_ctrl
module prwd_datapath import prwd_pkg::*; #(
	parameter int NUM_SERVICES        = 16,
	parameter int WORKERS_PER_SERVICE = 8,
	parameter int VALUE_BITS          = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  req_item_t  req_data,
	input  ctrl_cmd_t  cmd,
	output dp_status_t stat,
	output rsp_item_t  rsp_data
);

	localparam int SLOT_COUNT = NUM_SERVICES * WORKERS_PER_SERVICE;
	localparam int ADDR_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W      = $clog2(WORKERS_PER_SERVICE + 1);

	// configuration registers
	logic [3:0] workers_q;
	logic [4:0] services_q;
	logic [7:0] threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			workers_q   <= CFG_WORKERS_RST;
			services_q  <= CFG_SERVICES_RST;
			threshold_q <= CFG_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WORKERS:   workers_q   <= cfg_data[3:0];
				CFG_SERVICES:  services_q  <= cfg_data[4:0];
				CFG_THRESHOLD: threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// decode of the incoming item
	logic  svc_ok, slot_ok;
	kind_t kind_d;

	always_comb begin
		svc_ok  = ({1'b0, req_data.service_index} < services_q) &&
		          (int'(req_data.service_index) < NUM_SERVICES);
		slot_ok = int'(req_data.worker_slot) < WORKERS_PER_SERVICE;
		case (req_data.req_type)
			REQ_LOAD:    kind_d = slot_ok ? KIND_LOAD : KIND_INVALID;
			REQ_SUBMIT:  kind_d = KIND_SUBMIT;
			REQ_RELEASE: kind_d = slot_ok ? KIND_RELEASE : KIND_INVALID;
			default:     kind_d = KIND_INVALID;
		endcase
		if (!svc_ok) kind_d = KIND_INVALID;
	end

	// captured item
	req_item_t item_q;
	kind_t     kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_INVALID;
		end else if (cmd.capture) begin
			kind_q <= kind_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= req_data;
	end

	// slots in use, clamped to the table width
	logic [CNT_W-1:0] used_n;
	assign used_n = (int'(workers_q) > WORKERS_PER_SERVICE) ?
	                CNT_W'(WORKERS_PER_SERVICE) : CNT_W'(workers_q);

	logic [VALUE_BITS-1:0] need_v, prio_v;
	assign need_v = VALUE_BITS'(item_q.resource_amount);
	assign prio_v = VALUE_BITS'(item_q.priority_value);

	// scan index and addresses
	logic [CNT_W-1:0]  idx_q;
	logic [ADDR_W-1:0] base_addr, scan_addr, slot_addr, clr_q;

	assign base_addr = ADDR_W'(int'(item_q.service_index) * WORKERS_PER_SERVICE);
	assign scan_addr = base_addr + ADDR_W'(idx_q);
	assign slot_addr = base_addr + ADDR_W'(item_q.worker_slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.scan_init) idx_q <= '0;
			else if (cmd.scan_issue) idx_q <= idx_q + CNT_W'(1);
			if (cmd.clear_step) clr_q <= clr_q + ADDR_W'(1);
		end
	end

	// priority and capacity table
	logic [2*VALUE_BITS-1:0] pc_mem [SLOT_COUNT];
	logic [2*VALUE_BITS-1:0] pc_rd_s1;

	always_ff @(posedge clk) begin
		if (cmd.load_write) pc_mem[slot_addr] <= {prio_v, need_v};
		if (cmd.scan_issue) pc_rd_s1 <= pc_mem[scan_addr];
	end

	// busy table, cleared by a sweep after reset
	logic              busy_mem [SLOT_COUNT];
	logic              busy_rd_s1;
	logic              busy_we, busy_wd;
	logic [ADDR_W-1:0] busy_waddr, busy_raddr;
	logic              grant_wr, rel_wr;
	logic [CNT_W-1:0]  best_q;

	always_comb begin
		busy_we    = cmd.clear_step || (cmd.commit && (grant_wr || rel_wr));
		busy_wd    = !cmd.clear_step && grant_wr;
		busy_waddr = cmd.clear_step ? clr_q :
		             grant_wr ? base_addr + ADDR_W'(best_q) : slot_addr;
		busy_raddr = cmd.scan_issue ? scan_addr : slot_addr;
	end

	always_ff @(posedge clk) begin
		if (busy_we) busy_mem[busy_waddr] <= busy_wd;
		if (cmd.scan_issue || cmd.busy_read) busy_rd_s1 <= busy_mem[busy_raddr];
	end

	// read tags
	logic             rd_valid_s1;
	logic [CNT_W-1:0] rd_idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			rd_idx_s1   <= '0;
		end else begin
			rd_valid_s1 <= cmd.scan_issue;
			rd_idx_s1   <= idx_q;
		end
	end

	// capability and best idle worker over the scanned slots
	logic                  capable_q, found_q;
	logic [VALUE_BITS-1:0] best_prio_q, rd_cap, rd_prio;
	logic                  fits;

	assign rd_cap  = pc_rd_s1[VALUE_BITS-1:0];
	assign rd_prio = pc_rd_s1[2*VALUE_BITS-1:VALUE_BITS];
	assign fits    = rd_cap >= need_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capable_q <= 1'b0;
			found_q   <= 1'b0;
		end else if (cmd.scan_init) begin
			capable_q <= 1'b0;
			found_q   <= 1'b0;
		end else if (rd_valid_s1) begin
			if (fits) capable_q <= 1'b1;
			if (fits && !busy_rd_s1 && (!found_q || rd_prio < best_prio_q)) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1 && fits && !busy_rd_s1 && (!found_q || rd_prio < best_prio_q)) begin
			best_q      <= rd_idx_s1;
			best_prio_q <= rd_prio;
		end
	end

	// counter updates and result
	logic [7:0]  waiting_q, wait_d;
	logic [15:0] rejected_q, rej_d;
	logic [2:0]  st_d, slot_d;

	always_comb begin
		wait_d   = waiting_q;
		rej_d    = rejected_q;
		st_d     = ST_INVALID;
		slot_d   = 3'd0;
		grant_wr = 1'b0;
		rel_wr   = 1'b0;
		case (kind_q)
			KIND_LOAD: st_d = ST_LOADED;
			KIND_RELEASE: begin
				st_d = ST_RELEASED;
				if (busy_rd_s1) begin
					rel_wr = 1'b1;
					if (waiting_q != 8'd0) wait_d = waiting_q - 8'd1;
				end
			end
			KIND_SUBMIT: begin
				if (!capable_q) begin
					st_d = ST_REJECTED;
					if (rejected_q != 16'hFFFF) rej_d = rejected_q + 16'd1;
				end else begin
					if (!item_q.is_retry && waiting_q != 8'hFF) wait_d = waiting_q + 8'd1;
					if (found_q) begin
						st_d     = ST_GRANTED;
						slot_d   = 3'(best_q);
						grant_wr = 1'b1;
					end else begin
						st_d = ST_RETRY;
					end
				end
			end
			default: st_d = ST_INVALID;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q  <= '0;
			rejected_q <= '0;
		end else if (cmd.commit) begin
			waiting_q  <= wait_d;
			rejected_q <= rej_d;
		end
	end

	// output register
	rsp_item_t rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.status         <= st_d;
			rsp_q.granted_slot   <= slot_d;
			rsp_q.waiting_count  <= wait_d;
			rsp_q.high_traffic   <= wait_d >= threshold_q;
			rsp_q.rejected_count <= rej_d;
		end
	end

	assign rsp_data = rsp_q;

	// status to the controller
	assign stat.kind       = kind_q;
	assign stat.no_workers = (used_n == '0);
	assign stat.scan_last  = (idx_q == used_n - CNT_W'(1));
	assign stat.clear_last = (clr_q == ADDR_W'(SLOT_COUNT - 1));

endmodule

// ----- rtl/priority_resource_worker_dispatcher_top.sv -----
// channel    | direction | transfer when
// req_*      | in        | req_valid high and req_stall low
// rsp_*      | out       | rsp_valid high and rsp_stall low
// cfg_*      | in        | cfg_we high
//
// a load, release or invalid item passes the dispatch and finish states to the result register;
// a request between them also scans min(workers_in_use, WORKERS_PER_SERVICE) slots serially
// via the table read port and drains, unless no slot is in use; one item is in work at a time.
// after reset the busy table is swept, all NUM_SERVICES * WORKERS_PER_SERVICE
// slots, before the first item is taken; config writes are taken throughout.
// a finished result waits in the output register while the next item is taken;
// that item holds in its last cycle until the output register is free.
`include "priority_resource_worker_dispatcher_top_assert.svh"
module priority_resource_worker_dispatcher_top import prwd_pkg::*; #(
	parameter int NUM_SERVICES        = 16,
	parameter int WORKERS_PER_SERVICE = 8,
	parameter int VALUE_BITS          = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  req_item_t  req_data,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_item_t  rsp_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	ctrl_cmd_t  cmd;
	dp_status_t stat;

	// sequencing
	prwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// tables, scan and counters
	prwd_datapath #(
		.NUM_SERVICES        (NUM_SERVICES),
		.WORKERS_PER_SERVICE (WORKERS_PER_SERVICE),
		.VALUE_BITS          (VALUE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_data  (req_data),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_data  (rsp_data)
	);

	// checks
	`PRWD_ASSERT_NEXT(a_busy_after_take, clk, arst_n, req_valid && !req_stall, req_stall)
	`PRWD_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.commit, !(rsp_valid && rsp_stall))
	`PRWD_ASSERT_NEXT(a_no_repeat, clk, arst_n, rsp_valid && !rsp_stall && !cmd.commit, !rsp_valid)
	`PRWD_ASSERT_IMP(a_slot_zero, clk, arst_n, rsp_valid && (rsp_data.status != ST_GRANTED), rsp_data.granted_slot == 3'd0)

endmodule
